/* src/sprite_frame_sequencer_macros.svh */
// Assertion macros for the sprite frame sequencer checker.
`ifndef SPRITE_FRAME_SEQUENCER_MACROS_SVH
`define SPRITE_FRAME_SEQUENCER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define SFS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sfs check failed");

// Next-cycle implication, sampled on clk, off during rst.
`define SFS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sfs check failed");

`endif

/* src/sfs_pkg.sv */
// Shared types, constants and codes of the sprite frame sequencer.
package sfs_pkg;

  // Sequence sizing default
  localparam int MAX_FRAMES = 256;

  // Field widths
  localparam int ELAPSED_W   = 24;
  localparam int PERIOD_W    = 24;
  localparam int SEQ_START_W = 8;
  localparam int SEQ_END_W   = 9;
  localparam int FPR_W       = 9;
  localparam int DIM_W       = 13;
  localparam int COORD_W     = 20;
  localparam int FRAME_NUM_W = 8;
  localparam int ENTRY_W     = 9;   // sequence entries stay below 511
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;

  // Shared divider: dividend holds a position advanced by a whole tick
  localparam int DIV_W       = 26;
  localparam int STEP_W      = 5;
  localparam int TIME_STEPS  = 25;
  localparam int POS_STEPS   = 26;

  // Register reset values
  localparam int PERIOD_RESET = 100000;

  // Request payloads
  typedef struct packed {
    logic [ELAPSED_W-1:0] elapsed_us;
    logic                 play;
  } tick_t;

  typedef struct packed {
    logic [FRAME_NUM_W-1:0] frame_number;
    logic [COORD_W-1:0]     src_x;
    logic [COORD_W-1:0]     src_y;
    logic                   ended;
  } result_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEQ_START      = 3'd0,
    REG_SEQ_END        = 3'd1,
    REG_PINGPONG       = 3'd2,
    REG_LOOP_ENABLE    = 3'd3,
    REG_FRAME_PERIOD   = 3'd4,
    REG_FRAMES_PER_ROW = 3'd5,
    REG_FRAME_WIDTH    = 3'd6,
    REG_FRAME_HEIGHT   = 3'd7
  } cfg_reg_e;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_TIME,
    S_TDIV,
    S_POS,
    S_PDIV,
    S_FRAME,
    S_CGO,
    S_FDIV,
    S_OUT
  } state_e;

  // Divider operand selection
  typedef enum logic [1:0] {
    DIV_TIME,
    DIV_POS,
    DIV_FRAME
  } div_op_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_SUM,
    ACC_REM
  } acc_sel_e;

  typedef enum logic [2:0] {
    POS_HOLD,
    POS_PPOS,
    POS_ADVANCE,
    POS_REM,
    POS_ZERO,
    POS_LEN
  } pos_sel_e;

  // Controller to datapath commands
  typedef struct packed {
    logic     capture;
    acc_sel_e acc_sel;
    pos_sel_e pos_sel;
    logic     div_start;
    div_op_e  div_op;
    logic     frame_load;
    logic     out_load;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic play;
    logic sum_lt_period;
    logic len_zero;
    logic loop_en;
    logic pos_lt_len;
    logic pos_gt_len;
    logic div_busy;
    logic out_free;
  } dp_status_t;

endpackage

/* src/sprite_frame_sequencer.sv */
// Top level of the sprite frame sequencer: controller and datapath.
//
//   channel   direction  handshake                 payload
//   tick      in         tick_valid / tick_stall   tick (elapsed_us, play)
//   result    out        result_valid / result_stall result (frame, src_x/y, ended)
//   cfg       in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// A request runs from acceptance through S_TIME, S_POS, S_FRAME, S_CGO,
// S_FDIV and S_OUT to the result register; a period division (S_TDIV) runs
// only when a whole frame period has elapsed and a position wrap (S_PDIV)
// only when needed, both on the shared bit-serial divider. Requests are taken
// only while the controller is idle; a finished result waits in the output
// register while the next request is accepted and computed.
// Reset (rst, synchronous) restores the register defaults, clears the
// accumulator and the position, and empties the result register.
module sprite_frame_sequencer #(
  parameter int MAX_FRAMES = sfs_pkg::MAX_FRAMES
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            tick_valid,
  output logic                            tick_stall,
  input  sfs_pkg::tick_t                  tick,
  output logic                            result_valid,
  input  logic                            result_stall,
  output sfs_pkg::result_t                result,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sfs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sfs_pkg::CFG_DATA_W-1:0]  cfg_data
);

  sfs_pkg::ctrl_cmd_t  cmd;
  sfs_pkg::dp_status_t status;

  sfs_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .tick_valid (tick_valid),
    .tick_stall (tick_stall),
    .cfg_ready  (cfg_ready),
    .status     (status),
    .cmd        (cmd)
  );

  sfs_dpath #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .tick         (tick),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .status       (status),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

/* src/sfs_div.sv */
// Shared restoring divider, one quotient bit per cycle.
module sfs_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [sfs_pkg::DIV_W-1:0]       dividend,
  input  logic [sfs_pkg::PERIOD_W-1:0]    divisor,
  input  logic [sfs_pkg::STEP_W-1:0]      steps,
  output logic                            busy,
  output logic [sfs_pkg::DIV_W-1:0]       quotient,
  output logic [sfs_pkg::PERIOD_W-1:0]    remainder
);

  logic [sfs_pkg::DIV_W-1:0]    quo;
  logic [sfs_pkg::PERIOD_W-1:0] rem;
  logic [sfs_pkg::PERIOD_W-1:0] dvs;
  logic [sfs_pkg::STEP_W-1:0]   cnt;
  logic [sfs_pkg::PERIOD_W:0]   trial;
  logic                         fits;
  logic [sfs_pkg::PERIOD_W-1:0] rem_next;

  // Trial subtract of the shifted partial remainder
  always_comb begin
    trial    = {rem, quo[sfs_pkg::DIV_W-1]};
    fits     = (trial >= {1'b0, dvs});
    rem_next = fits ? sfs_pkg::PERIOD_W'(trial - {1'b0, dvs})
                    : trial[sfs_pkg::PERIOD_W-1:0];
  end

  // Run flag
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && (cnt == sfs_pkg::STEP_W'(1))) begin
      busy <= 1'b0;
    end
  end

  // Operands and iteration
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
      cnt <= steps;
    end else if (busy) begin
      quo <= {quo[sfs_pkg::DIV_W-2:0], fits};
      rem <= rem_next;
      cnt <= cnt - sfs_pkg::STEP_W'(1);
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

/* src/sfs_ctrl.sv */
// Sequencing state machine of the sprite frame sequencer.
module sfs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                tick_valid,
  output logic                tick_stall,
  output logic                cfg_ready,
  input  sfs_pkg::dp_status_t status,
  output sfs_pkg::ctrl_cmd_t  cmd
);

  sfs_pkg::state_e state;
  sfs_pkg::state_e state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sfs_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign tick_stall = (state != sfs_pkg::S_IDLE);
  assign cfg_ready  = (state == sfs_pkg::S_IDLE);

  // Next state and commands
  always_comb begin
    state_next     = state;
    cmd.capture    = 1'b0;
    cmd.acc_sel    = sfs_pkg::ACC_HOLD;
    cmd.pos_sel    = sfs_pkg::POS_HOLD;
    cmd.div_start  = 1'b0;
    cmd.div_op     = sfs_pkg::DIV_FRAME;
    cmd.frame_load = 1'b0;
    cmd.out_load   = 1'b0;
    case (state)
      sfs_pkg::S_IDLE: begin
        if (tick_valid) begin
          cmd.capture = 1'b1;
          state_next  = sfs_pkg::S_TIME;
        end
      end
      // Add the tick while playing; divide only when a whole period has gone by
      sfs_pkg::S_TIME: begin
        if (!status.play) begin
          cmd.pos_sel = sfs_pkg::POS_PPOS;
          state_next  = sfs_pkg::S_POS;
        end else if (status.sum_lt_period) begin
          cmd.acc_sel = sfs_pkg::ACC_SUM;
          cmd.pos_sel = sfs_pkg::POS_PPOS;
          state_next  = sfs_pkg::S_POS;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_op    = sfs_pkg::DIV_TIME;
          state_next    = sfs_pkg::S_TDIV;
        end
      end
      sfs_pkg::S_TDIV: begin
        if (!status.div_busy) begin
          cmd.acc_sel = sfs_pkg::ACC_REM;
          cmd.pos_sel = sfs_pkg::POS_ADVANCE;
          state_next  = sfs_pkg::S_POS;
        end
      end
      // Wrap, clamp or zero the position
      sfs_pkg::S_POS: begin
        if (status.len_zero) begin
          cmd.pos_sel = sfs_pkg::POS_ZERO;
          state_next  = sfs_pkg::S_FRAME;
        end else if (status.loop_en) begin
          if (status.pos_lt_len) begin
            state_next = sfs_pkg::S_FRAME;
          end else begin
            cmd.div_start = 1'b1;
            cmd.div_op    = sfs_pkg::DIV_POS;
            state_next    = sfs_pkg::S_PDIV;
          end
        end else begin
          if (status.pos_gt_len) begin
            cmd.pos_sel = sfs_pkg::POS_LEN;
          end
          state_next = sfs_pkg::S_FRAME;
        end
      end
      sfs_pkg::S_PDIV: begin
        if (!status.div_busy) begin
          cmd.pos_sel = sfs_pkg::POS_REM;
          state_next  = sfs_pkg::S_FRAME;
        end
      end
      sfs_pkg::S_FRAME: begin
        cmd.frame_load = 1'b1;
        state_next     = sfs_pkg::S_CGO;
      end
      // Split the frame into sheet column and row
      sfs_pkg::S_CGO: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = sfs_pkg::DIV_FRAME;
        state_next    = sfs_pkg::S_FDIV;
      end
      sfs_pkg::S_FDIV: begin
        if (!status.div_busy) begin
          state_next = sfs_pkg::S_OUT;
        end
      end
      sfs_pkg::S_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = sfs_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = sfs_pkg::S_IDLE;
      end
    endcase
  end

endmodule

/* src/sfs_dpath.sv */
// Datapath: registers, sequence arithmetic, divider and result register.
module sfs_dpath #(
  parameter int MAX_FRAMES = sfs_pkg::MAX_FRAMES
) (
  input  logic                             clk,
  input  logic                             rst,
  input  sfs_pkg::tick_t                   tick,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [sfs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sfs_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  sfs_pkg::ctrl_cmd_t               cmd,
  output sfs_pkg::dp_status_t              status,
  input  logic                             result_stall,
  output logic                             result_valid,
  output sfs_pkg::result_t                 result
);

  localparam int POS_W = $clog2(2 * MAX_FRAMES);
  localparam int EW    = (POS_W > sfs_pkg::SEQ_END_W) ? POS_W : sfs_pkg::SEQ_END_W;

  // Configuration registers
  logic [sfs_pkg::SEQ_START_W-1:0] seq_start;
  logic [sfs_pkg::SEQ_END_W-1:0]   seq_end;
  logic                            pingpong;
  logic                            loop_en;
  logic [sfs_pkg::PERIOD_W-1:0]    frame_period;
  logic [sfs_pkg::FPR_W-1:0]       frames_per_row;
  logic [sfs_pkg::DIM_W-1:0]       frame_width;
  logic [sfs_pkg::DIM_W-1:0]       frame_height;

  // Play state and per-request registers
  logic [sfs_pkg::PERIOD_W-1:0]    acc;
  logic [POS_W-1:0]                ppos;
  logic [sfs_pkg::ELAPSED_W-1:0]   elapsed;
  logic                            play;
  logic [sfs_pkg::DIV_W-1:0]       pos;
  logic [EW-1:0]                   frame;
  logic                            ended;

  // Derived values
  logic [sfs_pkg::PERIOD_W-1:0]    period_eff;
  logic [sfs_pkg::FPR_W-1:0]       fpr_eff;
  logic [EW-1:0]                   eff_end;
  logic [EW-1:0]                   fwd;
  logic [EW-1:0]                   back;
  logic [EW-1:0]                   len;
  logic [sfs_pkg::PERIOD_W:0]      sum;
  logic [POS_W-1:0]                pos_n;
  logic                            at_end;
  logic [EW-1:0]                   used;
  logic [EW-1:0]                   entry;
  logic [EW-1:0]                   frame_c;
  logic                            cfg_we;

  // Divider hookup
  logic [sfs_pkg::DIV_W-1:0]       div_dividend;
  logic [sfs_pkg::PERIOD_W-1:0]    div_divisor;
  logic [sfs_pkg::STEP_W-1:0]      div_steps;
  logic                            div_busy;
  logic [sfs_pkg::DIV_W-1:0]       div_quo;
  logic [sfs_pkg::PERIOD_W-1:0]    div_rem;

  assign cfg_we = cfg_valid && cfg_ready;

  // Sequence geometry from the registers
  always_comb begin
    period_eff = (frame_period == '0) ? sfs_pkg::PERIOD_W'(1) : frame_period;
    fpr_eff    = (frames_per_row == '0) ? sfs_pkg::FPR_W'(1) : frames_per_row;
    eff_end    = (EW'(seq_end) > EW'(MAX_FRAMES)) ? EW'(MAX_FRAMES) : EW'(seq_end);
    fwd        = (eff_end > EW'(seq_start)) ? eff_end - EW'(seq_start) : '0;
    back       = (pingpong && (fwd >= EW'(2))) ? fwd - EW'(2) : '0;
    len        = fwd + back + EW'(pingpong && !loop_en);
    sum        = {1'b0, acc} + {1'b0, elapsed};
  end

  // Entry shown at the settled position; at the end it is the last one
  always_comb begin
    pos_n  = POS_W'(pos);
    at_end = (EW'(pos_n) == len);
    used   = at_end ? len - EW'(1) : EW'(pos_n);
    if (used < fwd) begin
      entry = EW'(seq_start) + used;
    end else if (used < fwd + back) begin
      entry = eff_end - EW'(2) - (used - fwd);
    end else begin
      entry = EW'(seq_start);
    end
    frame_c = (len == '0) ? EW'(seq_start) : entry;
  end

  // Status to the controller
  always_comb begin
    status.play          = play;
    status.sum_lt_period = (sum < {1'b0, period_eff});
    status.len_zero      = (len == '0);
    status.loop_en       = loop_en;
    status.pos_lt_len    = (pos < sfs_pkg::DIV_W'(len));
    status.pos_gt_len    = (pos > sfs_pkg::DIV_W'(len));
    status.div_busy      = div_busy;
    status.out_free      = !result_valid || !result_stall;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      seq_start      <= '0;
      seq_end        <= sfs_pkg::SEQ_END_W'(1);
      pingpong       <= 1'b0;
      loop_en        <= 1'b1;
      frame_period   <= sfs_pkg::PERIOD_W'(sfs_pkg::PERIOD_RESET);
      frames_per_row <= sfs_pkg::FPR_W'(1);
      frame_width    <= sfs_pkg::DIM_W'(1);
      frame_height   <= sfs_pkg::DIM_W'(1);
    end else if (cfg_we) begin
      case (sfs_pkg::cfg_reg_e'(cfg_index))
        sfs_pkg::REG_SEQ_START:      seq_start      <= cfg_data[sfs_pkg::SEQ_START_W-1:0];
        sfs_pkg::REG_SEQ_END:        seq_end        <= cfg_data[sfs_pkg::SEQ_END_W-1:0];
        sfs_pkg::REG_PINGPONG:       pingpong       <= cfg_data[0];
        sfs_pkg::REG_LOOP_ENABLE:    loop_en        <= cfg_data[0];
        sfs_pkg::REG_FRAME_PERIOD:   frame_period   <= cfg_data[sfs_pkg::PERIOD_W-1:0];
        sfs_pkg::REG_FRAMES_PER_ROW: frames_per_row <= cfg_data[sfs_pkg::FPR_W-1:0];
        sfs_pkg::REG_FRAME_WIDTH:    frame_width    <= cfg_data[sfs_pkg::DIM_W-1:0];
        sfs_pkg::REG_FRAME_HEIGHT:   frame_height   <= cfg_data[sfs_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Play position: restarts on a sequence register write
  always_ff @(posedge clk) begin
    if (rst) begin
      ppos <= '0;
    end else if (cfg_we && ((sfs_pkg::cfg_reg_e'(cfg_index) == sfs_pkg::REG_SEQ_START) ||
                            (sfs_pkg::cfg_reg_e'(cfg_index) == sfs_pkg::REG_SEQ_END) ||
                            (sfs_pkg::cfg_reg_e'(cfg_index) == sfs_pkg::REG_PINGPONG) ||
                            (sfs_pkg::cfg_reg_e'(cfg_index) == sfs_pkg::REG_LOOP_ENABLE))) begin
      ppos <= '0;
    end else if (cmd.frame_load) begin
      ppos <= pos_n;
    end
  end

  // Time accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else begin
      case (cmd.acc_sel)
        sfs_pkg::ACC_SUM:  acc <= sum[sfs_pkg::PERIOD_W-1:0];
        sfs_pkg::ACC_REM:  acc <= div_rem;
        default:           acc <= acc;
      endcase
    end
  end

  // Captured request and working position
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      elapsed <= tick.elapsed_us;
      play    <= tick.play;
    end
    case (cmd.pos_sel)
      sfs_pkg::POS_PPOS:    pos <= sfs_pkg::DIV_W'(ppos);
      sfs_pkg::POS_ADVANCE: pos <= sfs_pkg::DIV_W'(ppos) + div_quo;
      sfs_pkg::POS_REM:     pos <= sfs_pkg::DIV_W'(div_rem);
      sfs_pkg::POS_ZERO:    pos <= '0;
      sfs_pkg::POS_LEN:     pos <= sfs_pkg::DIV_W'(len);
      default:              pos <= pos;
    endcase
    if (cmd.frame_load) begin
      frame <= frame_c;
      ended <= !loop_en && at_end;
    end
  end

  // Divider operands, left-aligned to the step count
  always_comb begin
    case (cmd.div_op)
      sfs_pkg::DIV_TIME: begin
        div_dividend = sfs_pkg::DIV_W'(sum) << (sfs_pkg::DIV_W - sfs_pkg::TIME_STEPS);
        div_divisor  = period_eff;
        div_steps    = sfs_pkg::STEP_W'(sfs_pkg::TIME_STEPS);
      end
      sfs_pkg::DIV_POS: begin
        div_dividend = pos << (sfs_pkg::DIV_W - sfs_pkg::POS_STEPS);
        div_divisor  = sfs_pkg::PERIOD_W'(len);
        div_steps    = sfs_pkg::STEP_W'(sfs_pkg::POS_STEPS);
      end
      sfs_pkg::DIV_FRAME: begin
        div_dividend = sfs_pkg::DIV_W'(frame) << (sfs_pkg::DIV_W - EW);
        div_divisor  = sfs_pkg::PERIOD_W'(fpr_eff);
        div_steps    = sfs_pkg::STEP_W'(EW);
      end
      default: begin
        div_dividend = '0;
        div_divisor  = sfs_pkg::PERIOD_W'(1);
        div_steps    = sfs_pkg::STEP_W'(1);
      end
    endcase
  end

  sfs_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .steps     (div_steps),
    .busy      (div_busy),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Result register: column and row scaled by the frame size
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result.frame_number <= frame[sfs_pkg::FRAME_NUM_W-1:0];
      result.src_x <= sfs_pkg::COORD_W'(div_rem[sfs_pkg::FPR_W-1:0] * frame_width);
      result.src_y <= sfs_pkg::COORD_W'(div_quo[EW-1:0] * frame_height);
      result.ended <= ended;
    end
  end

endmodule

/* src/sfs_checker.sv */
// Port-level checker for the sprite frame sequencer, bound to the top level.
`include "sprite_frame_sequencer_macros.svh"

module sfs_checker (
  input logic             clk,
  input logic             rst,
  input logic             tick_valid,
  input logic             tick_stall,
  input logic             result_valid,
  input logic             result_stall,
  input sfs_pkg::result_t result,
  input logic             cfg_ready
);

  // A stalled result stays put
  `SFS_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result))

  // Configuration is open only while requests are taken
  `SFS_ASSERT_SAME(a_cfg_idle, cfg_ready, !tick_stall)

  // An accepted request keeps the block busy in the next cycle
  `SFS_ASSERT_NEXT(a_busy_after_accept, tick_valid && !tick_stall, tick_stall)

  // A new result follows a busy cycle
  `SFS_ASSERT_SAME(a_result_from_work, $rose(result_valid), $past(tick_stall))

endmodule

bind sprite_frame_sequencer sfs_checker u_sfs_checker (.*);
